// File: hw/rtl/dct_pkg.sv
// Shared constants and types for the DRAM command timing checker.
package dct_pkg;

  // Default sizes, handed to the top level parameters
  localparam int NUM_RANKS_DEF  = 4;
  localparam int NUM_BANKS_DEF  = 8;
  localparam int ROW_BITS_DEF   = 16;
  localparam int STAMP_BITS_DEF = 32;

  // Fixed field widths
  localparam int MODE_W    = 3;
  localparam int RANK_W    = 2;
  localparam int BANK_W    = 3;
  localparam int TIME_W    = 8;
  localparam int CFG_IDX_W = 3;

  // Command codes; nop and unused codes fall to the default arm
  localparam logic [MODE_W-1:0] CMD_ACTIVATE  = 3'd1;
  localparam logic [MODE_W-1:0] CMD_PRECHARGE = 3'd2;
  localparam logic [MODE_W-1:0] CMD_READ      = 3'd3;
  localparam logic [MODE_W-1:0] CMD_WRITE     = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_T_RC   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_T_RP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_T_RRD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_T_RCDR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_T_RCDW = 3'd4;

  // Configuration reset values
  localparam logic [TIME_W-1:0] T_RC_RST   = 8'd40;
  localparam logic [TIME_W-1:0] T_RP_RST   = 8'd12;
  localparam logic [TIME_W-1:0] T_RRD_RST  = 8'd6;
  localparam logic [TIME_W-1:0] T_RCDR_RST = 8'd12;
  localparam logic [TIME_W-1:0] T_RCDW_RST = 8'd12;

  typedef struct packed {
    logic rc;
    logic rp;
    logic rrd;
    logic rcd_read;
    logic rcd_write;
  } viol_t;

endpackage

// File: hw/rtl/dram_command_timing_checker.sv
// DRAM command timing checker: top level.
//
// Usage: every command slot of the monitored bus is sent as one input
// transaction (mode, rank_sel, bank_sel, row_addr) on in_valid/in_stall. Each
// input transaction yields exactly one output transaction on
// out_valid/out_stall carrying the five timing violation flags and their OR.
// Timing registers are written on cfg_valid/cfg_ready (cfg_ready is always
// high); writes must go in only while no transaction is in flight, a rule
// for the user that the block does not enforce. A command passes the input
// register, then the result register, and a held result keeps it waiting.
// Throughput: one command per cycle while the result side does not stall;
// all per-bank time stamp compares run in parallel in the single logic stage.
// Time is counted in accepted commands, not clocks, with a STAMP_BITS wrap.
// Reset: counter and all stamps go to zero, no bank is open, no rank has an
// active bank, timing registers take their defaults, both channels empty.
// Stall: while a result is held, one more command is taken into the empty
// input register; once that register is full in_stall rises and it keeps its
// command until the result side frees up.
module dram_command_timing_checker
  import dct_pkg::*;
#(
  parameter int NUM_RANKS  = NUM_RANKS_DEF,
  parameter int NUM_BANKS  = NUM_BANKS_DEF,
  parameter int ROW_BITS   = ROW_BITS_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // command channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MODE_W-1:0]    mode,
  input  logic [RANK_W-1:0]    rank_sel,
  input  logic [BANK_W-1:0]    bank_sel,
  input  logic [ROW_BITS-1:0]  row_addr,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 rc_violation,
  output logic                 rp_violation,
  output logic                 rrd_violation,
  output logic                 rcd_read_violation,
  output logic                 rcd_write_violation,
  output logic                 any_violation,
  // configuration channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data
);

  localparam int NUM_ENTRIES = NUM_RANKS * NUM_BANKS;

  // timing registers
  logic [TIME_W-1:0] t_rc, t_rp, t_rrd, t_rcdr, t_rcdw;

  // input register
  logic                s1_valid;
  logic [MODE_W-1:0]   s1_mode;
  logic [RANK_W-1:0]   s1_rank;
  logic [BANK_W-1:0]   s1_bank;
  logic [ROW_BITS-1:0] s1_row;

  logic [STAMP_BITS-1:0] now;

  // per-bank and per-rank state
  logic [STAMP_BITS-1:0] act_stamp [NUM_ENTRIES];
  logic [STAMP_BITS-1:0] pre_stamp [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] row_open;
  logic [ROW_BITS-1:0]   open_row  [NUM_ENTRIES];
  logic [NUM_RANKS-1:0]  rank_bank_valid;
  logic [BANK_W-1:0]     rank_bank [NUM_RANKS];

  // decode and compare results
  logic [NUM_RANKS-1:0]   rank_hit;
  logic [NUM_BANKS-1:0]   bank_hit;
  logic [NUM_RANKS-1:0]   same_bank_vec;
  logic [NUM_ENTRIES-1:0] entry_hit, entry_in_rank;
  logic [NUM_ENTRIES-1:0] soon_rc, soon_rp, soon_rrd, soon_rcdr, soon_rcdw;

  logic  accept, advance, in_range, rank_act_valid, same_bank;
  logic  do_act, do_pre;
  viol_t viol;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && out_valid && out_stall;

  // address decode
  for (genvar r = 0; r < NUM_RANKS; r++) begin : g_rank_dec
    assign rank_hit[r]      = (int'(s1_rank) == r);
    assign same_bank_vec[r] = (rank_bank[r] == s1_bank);
  end
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank_dec
    assign bank_hit[b] = (int'(s1_bank) == b);
  end

  assign in_range       = (|rank_hit) && (|bank_hit);
  assign rank_act_valid = |(rank_hit & rank_bank_valid);
  assign same_bank      = |(rank_hit & rank_bank_valid & same_bank_vec);
  assign do_act = advance && in_range && (s1_mode == CMD_ACTIVATE);
  assign do_pre = advance && in_range && (s1_mode == CMD_PRECHARGE);

  // per-bank age compares, all banks in parallel
  for (genvar r = 0; r < NUM_RANKS; r++) begin : g_rank
    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      localparam int K = r * NUM_BANKS + b;
      logic [STAMP_BITS-1:0] act_age, pre_age;
      logic                  act_near, pre_near;

      assign act_age  = now - act_stamp[K];
      assign pre_age  = now - pre_stamp[K];
      // age below 2^TIME_W: upper bits all clear
      assign act_near = ~|act_age[STAMP_BITS-1:TIME_W];
      assign pre_near = ~|pre_age[STAMP_BITS-1:TIME_W];

      assign entry_hit[K]     = rank_hit[r] && bank_hit[b];
      assign entry_in_rank[K] = rank_hit[r];
      assign soon_rc[K]   = act_near && (act_age[TIME_W-1:0] < t_rc);
      assign soon_rrd[K]  = act_near && (act_age[TIME_W-1:0] < t_rrd);
      assign soon_rcdr[K] = act_near && (act_age[TIME_W-1:0] < t_rcdr);
      assign soon_rcdw[K] = act_near && (act_age[TIME_W-1:0] < t_rcdw);
      assign soon_rp[K]   = pre_near && (pre_age[TIME_W-1:0] < t_rp);

      always_ff @(posedge clk) begin
        if (rst) begin
          act_stamp[K] <= '0;
          pre_stamp[K] <= '0;
          row_open[K]  <= 1'b0;
        end else if (do_act && entry_hit[K]) begin
          act_stamp[K] <= now;
          row_open[K]  <= 1'b1;
        end else if (do_pre && entry_hit[K]) begin
          pre_stamp[K] <= now;
          row_open[K]  <= 1'b0;
        end
      end

      always_ff @(posedge clk) begin
        if (do_act && entry_hit[K]) begin
          open_row[K] <= s1_row;
        end else if (do_pre && entry_hit[K]) begin
          open_row[K] <= '0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rank_bank_valid[r] <= 1'b0;
      end else if (do_act && rank_hit[r]) begin
        rank_bank_valid[r] <= 1'b1;
      end else if (do_pre && rank_hit[r]) begin
        rank_bank_valid[r] <= 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (do_act && rank_hit[r]) begin
        rank_bank[r] <= s1_bank;
      end
    end
  end

  always_comb begin
    viol = '0;
    if (in_range) begin
      case (s1_mode)
        CMD_ACTIVATE: begin
          if (rank_act_valid) begin
            if (same_bank) begin
              viol.rc = |(entry_hit & soon_rc);
              viol.rp = |(entry_hit & soon_rp);
            end else begin
              viol.rrd = |(entry_in_rank & soon_rrd);
            end
          end
        end
        CMD_READ:  viol.rcd_read  = |(entry_hit & soon_rcdr);
        CMD_WRITE: viol.rcd_write = |(entry_hit & soon_rcdw);
        default: ;
      endcase
    end
  end

  // control: channels, counter, configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      now       <= '0;
      t_rc      <= T_RC_RST;
      t_rp      <= T_RP_RST;
      t_rrd     <= T_RRD_RST;
      t_rcdr    <= T_RCDR_RST;
      t_rcdw    <= T_RCDW_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_T_RC:   t_rc   <= cfg_data;
          REG_T_RP:   t_rp   <= cfg_data;
          REG_T_RRD:  t_rrd  <= cfg_data;
          REG_T_RCDR: t_rcdr <= cfg_data;
          REG_T_RCDW: t_rcdw <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        now       <= now + STAMP_BITS'(1);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode <= mode;
      s1_rank <= rank_sel;
      s1_bank <= bank_sel;
      s1_row  <= row_addr;
    end
    if (advance) begin
      rc_violation        <= viol.rc;
      rp_violation        <= viol.rp;
      rrd_violation       <= viol.rrd;
      rcd_read_violation  <= viol.rcd_read;
      rcd_write_violation <= viol.rcd_write;
      any_violation       <= |viol;
    end
  end

endmodule

// File: hw/rtl/dct_checker.sv
// Port-level assertions for the DRAM command timing checker, bound to the top.
module dct_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic rc_violation,
  input logic rp_violation,
  input logic rrd_violation,
  input logic rcd_read_violation,
  input logic rcd_write_violation,
  input logic any_violation
);

  // the summary flag is the OR of the individual flags
  a_any_or: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (any_violation == (rc_violation || rp_violation || rrd_violation ||
                                     rcd_read_violation || rcd_write_violation)))
    else $error("any_violation does not match the individual flags");

  // one command kind per slot: activate flags, read flag, write flag exclude each other;
  // a same-bank activate never reports tRRD
  a_flag_groups: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($countones({rc_violation || rp_violation, rrd_violation,
                               rcd_read_violation, rcd_write_violation}) <= 1))
    else $error("violation flags from different command kinds in one result");

  // input side only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with the result side free");

  // result channel empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // a held result keeps its summary, tRC and tRRD flags
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(any_violation) &&
                                  $stable(rc_violation) && $stable(rrd_violation)))
    else $error("stalled result changed");

endmodule

bind dram_command_timing_checker dct_checker u_dct_checker (.*);
